// ----- rtl/core/random_sample_set_table_macros.svh -----
// ----------------------------------------------------------------------------
// Random sample set table: assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef RANDOM_SAMPLE_SET_TABLE_MACROS_SVH
`define RANDOM_SAMPLE_SET_TABLE_MACROS_SVH

// Same-cycle implication under reset.
`define RSST_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define RSST_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/rsst_pkg.sv -----
// ----------------------------------------------------------------------------
// Random sample set table: package
// Widths, request and status codes shared by the block.
// ----------------------------------------------------------------------------
package rsst_pkg;

    localparam int WORD_W   = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 3;

    typedef logic [REQ_W-1:0]    req_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [WORD_W-1:0]   word_t;

    localparam req_t OP_INSERT = 2'd0;
    localparam req_t OP_REMOVE = 2'd1;
    localparam req_t OP_SAMPLE = 2'd2;

    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_PRESENT = 3'd1;
    localparam status_t ST_ABSENT  = 3'd2;
    localparam status_t ST_FULL    = 3'd3;
    localparam status_t ST_EMPTY   = 3'd4;

endpackage

// ----- rtl/core/rsst_if.sv -----
// ----------------------------------------------------------------------------
// Random sample set table: channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsst_req_if;
    import rsst_pkg::*;

    logic               valid;
    logic               ready;
    req_t               req_type;
    logic signed [31:0] key_value;
    logic [31:0]        random_word;

    modport source (output valid, output req_type, output key_value, output random_word,
                    input ready);
    modport sink   (input valid, input req_type, input key_value, input random_word,
                    output ready);
endinterface

interface rsst_rsp_if;
    import rsst_pkg::*;

    logic               valid;
    logic               ready;
    logic               success;
    logic signed [31:0] sample_value;
    status_t            status;

    modport source (output valid, output success, output sample_value, output status,
                    input ready);
    modport sink   (input valid, input success, input sample_value, input status,
                    output ready);
endinterface

// ----- rtl/core/random_sample_set_table.sv -----
// Insert/remove: linear scan of the live entries, one entry per cycle, plus the move of
//   the last entry into the freed slot on remove; sample: 32-step modulo unit.
// Throughput: one word at a time; ready only while the sequencer is idle.
// The scan over the entry memory and the bit-serial modulo set the time each word takes.
// Reset clears the live count and the handshake state; the entry memory is not cleared.
// ----------------------------------------------------------------------------
// Random sample set table: top level
// Set of distinct 32-bit values in a dense array with insert, remove and sample.
// ----------------------------------------------------------------------------
module random_sample_set_table #(
    parameter int CAPACITY = 256
) (
    input  logic clk,
    input  logic rst_n,
    rsst_req_if.sink   req,
    rsst_rsp_if.source rsp
);
    import rsst_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SCAN      = 3'd1;
    localparam logic [2:0] S_MOVE_RD   = 3'd2;
    localparam logic [2:0] S_MOVE_WR   = 3'd3;
    localparam logic [2:0] S_MOD       = 3'd4;
    localparam logic [2:0] S_SAMP_RD   = 3'd5;
    localparam logic [2:0] S_SAMP_DATA = 3'd6;
    localparam logic [2:0] S_RESP      = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic          rd_vld_reg, rd_vld_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic [IW-1:0] slot_reg, slot_next;
    req_t          op_reg, op_next;
    word_t         key_reg, key_next;

    logic          res_ok_reg, res_ok_next;
    word_t         res_val_reg, res_val_next;
    status_t       res_st_reg, res_st_next;

    logic          out_valid_reg, out_valid_next;
    logic          out_ok_reg, out_ok_next;
    word_t         out_val_reg, out_val_next;
    status_t       out_st_reg, out_st_next;

    word_t         mem [CAPACITY];
    word_t         rd_data_reg;
    logic          rd_en, wr_en;
    logic [IW-1:0] rd_addr, wr_addr;
    word_t         wr_data;

    logic          mod_start, mod_done;
    logic [CW-1:0] mod_rem;
    logic [CW-1:0] last_idx;
    logic          issuing, hit;

    rsst_modulo #(.CW(CW)) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (req.random_word),
        .divisor   (count_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign last_idx = count_reg - CW'(1);
    assign issuing  = scan_reg < count_reg;
    assign hit      = rd_vld_reg && (rd_data_reg == key_reg);
    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        slot_next      = slot_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        res_ok_next    = res_ok_reg;
        res_val_next   = res_val_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_ok_next    = out_ok_reg;
        out_val_next   = out_val_reg;
        out_st_next    = out_st_reg;
        rd_en          = 1'b0;
        rd_addr        = scan_reg[IW-1:0];
        wr_en          = 1'b0;
        wr_addr        = count_reg[IW-1:0];
        wr_data        = key_reg;
        mod_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next      = req.req_type;
                    key_next     = req.key_value;
                    res_ok_next  = 1'b0;
                    res_val_next = '0;
                    res_st_next  = ST_OK;
                    scan_next    = '0;
                    priority if (req.req_type == OP_INSERT || req.req_type == OP_REMOVE)
                        state_next = S_SCAN;
                    else if (req.req_type == OP_SAMPLE)
                    begin
                        if (count_reg == '0)
                        begin
                            res_st_next = ST_EMPTY;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            mod_start  = 1'b1;
                            state_next = S_MOD;
                        end
                    end
                    else
                        state_next = S_RESP;
                end
            end
            S_SCAN:
            begin
                priority if (hit)
                begin
                    slot_next = rd_idx_reg;
                    if (op_reg == OP_INSERT)
                    begin
                        res_st_next = ST_PRESENT;
                        state_next  = S_RESP;
                    end
                    else
                        state_next = S_MOVE_RD;
                end
                else if (!issuing)
                begin
                    state_next = S_RESP;
                    if (op_reg == OP_REMOVE)
                        res_st_next = ST_ABSENT;
                    else if (count_reg == CAP_C)
                        res_st_next = ST_FULL;
                    else
                    begin
                        wr_en       = 1'b1;
                        count_next  = count_reg + CW'(1);
                        res_ok_next = 1'b1;
                    end
                end
                else
                begin
                    rd_en       = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = scan_reg[IW-1:0];
                    scan_next   = scan_reg + CW'(1);
                end
            end
            S_MOVE_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = last_idx[IW-1:0];
                state_next = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                wr_en       = 1'b1;
                wr_addr     = slot_reg;
                wr_data     = rd_data_reg;
                count_next  = last_idx;
                res_ok_next = 1'b1;
                state_next  = S_RESP;
            end
            S_MOD:
            begin
                if (mod_done)
                    state_next = S_SAMP_RD;
            end
            S_SAMP_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = mod_rem[IW-1:0];
                state_next = S_SAMP_DATA;
            end
            S_SAMP_DATA:
            begin
                res_val_next = rd_data_reg;
                res_ok_next  = 1'b1;
                state_next   = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_val_next   = res_val_reg;
                    out_st_next    = res_st_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg    <= scan_next;
        rd_idx_reg  <= rd_idx_next;
        slot_reg    <= slot_next;
        op_reg      <= op_next;
        key_reg     <= key_next;
        res_ok_reg  <= res_ok_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
        out_ok_reg  <= out_ok_next;
        out_val_reg <= out_val_next;
        out_st_reg  <= out_st_next;
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.success      = out_ok_reg;
    assign rsp.sample_value = out_val_reg;
    assign rsp.status       = out_st_reg;

endmodule

// ----- rtl/core/rsst_modulo.sv -----
// ----------------------------------------------------------------------------
// Random sample set table: iterative modulo unit
// Restoring remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module rsst_modulo #(
    parameter int CW = 9
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [rsst_pkg::WORD_W-1:0] dividend,
    input  logic [CW-1:0]            divisor,
    output logic                     done,
    output logic [CW-1:0]            remainder
);
    import rsst_pkg::*;

    localparam int NW = $clog2(WORD_W);
    localparam logic [NW-1:0] LAST_STEP = NW'(WORD_W - 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    word_t         dvd_reg, dvd_next;
    logic [CW-1:0] dsr_reg, dsr_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [CW:0]   trial;
    logic [CW:0]   diff;

    assign trial = {rem_reg, dvd_reg[WORD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << 1;
            if (trial >= {1'b0, dsr_reg})
                rem_next = diff[CW-1:0];
            else
                rem_next = trial[CW-1:0];
            cnt_next = cnt_reg + NW'(1);
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/core/rsst_checker.sv -----
// ----------------------------------------------------------------------------
// Random sample set table: port checker
// Temporal checks on the request and response ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "random_sample_set_table_macros.svh"

module rsst_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     req_valid,
    input logic                     req_ready,
    input logic                     rsp_valid,
    input logic                     rsp_ready,
    input logic                     rsp_success,
    input logic [31:0]              rsp_sample_value,
    input logic [rsst_pkg::STATUS_W-1:0] rsp_status
);
    import rsst_pkg::*;

    `RSST_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_success) && $stable(rsp_sample_value) && $stable(rsp_status),
        "stalled response word changed")
    `RSST_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready,
        "request taken while a word is in work")
    `RSST_ASSERT_NOW(a_success_ok, clk, rst_n, rsp_valid && rsp_success, rsp_status == ST_OK,
        "successful word with error status")
    `RSST_ASSERT_NOW(a_fail_zero, clk, rst_n, rsp_valid && rsp_status != ST_OK,
        !rsp_success && rsp_sample_value == '0, "failed word with value or success")

endmodule

bind random_sample_set_table rsst_checker u_rsst_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_success      (rsp.success),
    .rsp_sample_value (rsp.sample_value),
    .rsp_status       (rsp.status)
);
